>>> hdl/ffve_pkg.sv
// Shared types, constants and helpers for the form field value extractor.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package ffve_pkg;

	localparam int unsigned MAX_TAG_CHARS = 8;
	localparam int unsigned TAG_LEN_W     = 4;
	localparam int unsigned RES_DEPTH     = 4;
	localparam int unsigned RES_PTR_W     = $clog2(RES_DEPTH);
	localparam int unsigned RES_LVL_W     = $clog2(RES_DEPTH + 1);

	// configuration register indexes
	localparam logic [1:0] REG_TAG_TEXT   = 2'd0;
	localparam logic [1:0] REG_TAG_LENGTH = 2'd1;
	localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

	localparam logic [63:0]          TAG_TEXT_RST   = 64'd0;
	localparam logic [TAG_LEN_W-1:0] TAG_LENGTH_RST = 4'd1;
	localparam logic [7:0]           MAX_LENGTH_RST = 8'd32;

	// result kinds
	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_DONE      = 2'd1;
	localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_SEEK_EQ,
		PH_VALUE,
		PH_ESCAPE,
		PH_DONE
	} phase_t;

	// escape digit tracking
	localparam logic [1:0] ESC_NONE    = 2'd0;
	localparam logic [1:0] ESC_ONE_HEX = 2'd1;
	localparam logic [1:0] ESC_BAD     = 2'd2;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_last;
	} body_word_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] decoded_byte;
		logic [7:0] value_length;
	} result_word_t;

	// up to two result words produced by a body word
	typedef struct packed {
		logic [1:0]   count;
		result_word_t first;
		result_word_t second;
	} result_pair_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A)
			return c + 8'd32;
		return c;
	endfunction

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return 5'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66)
			return 5'(c - 8'h61 + 8'd10);
		if (c >= 8'h41 && c <= 8'h46)
			return 5'(c - 8'h41 + 8'd10);
		return 5'd16;
	endfunction

	function automatic result_word_t make_result(input logic [1:0] kind,
			input logic [7:0] data, input logic [7:0] len);
		result_word_t r;
		r.result_kind  = kind;
		r.decoded_byte = data;
		r.value_length = len;
		return r;
	endfunction

endpackage

>>> hdl/ffve_cell.sv
// One position of the tag match window: holds a byte, passes it on, compares.
// Depends on ffve_pkg.
`timescale 1ns / 1ps

module ffve_cell
	import ffve_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] din,
	input  logic [7:0] tag_char,
	input  logic       active,
	output logic [7:0] dout,
	output logic       hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

	// compare against the byte this cell takes on the shift
	assign hit = !active || (tag_char != 8'd0 && fold_case(tag_char) == fold_case(din));

endmodule

>>> hdl/ffve_ctrl.sv
// Extraction sequencer: phase, escape decode and emitted count per body word.
// Depends on ffve_pkg; takes the window match from the cell row.
`timescale 1ns / 1ps

module ffve_ctrl
	import ffve_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  body_word_t           body,
	input  logic                 tag_match,
	input  logic                 len_zero,
	input  logic [7:0]           max_len,
	output phase_t               phase,
	output result_pair_t         res
);

	phase_t     phase_q, ph_n;
	logic [1:0] seen_q, seen_n;
	logic [7:0] acc_q, acc_n;
	logic [7:0] cnt_q, cnt_n;
	logic       fin, emit;
	logic [7:0] emit_byte;
	logic [4:0] hv;
	logic [7:0] b;

	assign b  = body.body_byte;
	assign hv = hex_value(b);

	always_comb begin
		ph_n      = phase_q;
		seen_n    = seen_q;
		acc_n     = acc_q;
		cnt_n     = cnt_q;
		fin       = 1'b0;
		emit      = 1'b0;
		emit_byte = '0;
		res       = '0;

		if (phase_q != PH_DONE && b == 8'd0) begin
			fin = 1'b1;
		end else if (phase_q != PH_DONE) begin
			if (phase_q == PH_SEARCH && len_zero)
				ph_n = PH_SEEK_EQ;
			case (ph_n)
				PH_SEARCH: begin
					if (tag_match)
						ph_n = PH_SEEK_EQ;
				end
				PH_SEEK_EQ: begin
					if (b == CH_EQ) begin
						ph_n = PH_VALUE;
						if (cnt_q >= max_len)
							fin = 1'b1;
					end
				end
				PH_VALUE: begin
					if (cnt_q >= max_len || b == CH_AMP) begin
						fin = 1'b1;
					end else if (b == CH_PCT) begin
						ph_n   = PH_ESCAPE;
						seen_n = ESC_NONE;
						acc_n  = '0;
					end else begin
						emit      = 1'b1;
						emit_byte = (b == CH_PLUS) ? CH_SPACE : b;
					end
				end
				PH_ESCAPE: begin
					if (seen_q == ESC_NONE) begin
						if (!hv[4]) begin
							acc_n  = {4'd0, hv[3:0]};
							seen_n = ESC_ONE_HEX;
						end else begin
							acc_n  = '0;
							seen_n = ESC_BAD;
						end
					end else begin
						emit_byte = acc_q;
						if (seen_q == ESC_ONE_HEX && !hv[4])
							emit_byte = {acc_q[3:0], hv[3:0]};
						acc_n  = emit_byte;
						seen_n = ESC_NONE;
						emit   = 1'b1;
					end
				end
				default: ;
			endcase
		end

		if (emit) begin
			res.first = make_result(KIND_BYTE, emit_byte, 8'd0);
			res.count = 2'd1;
			cnt_n     = cnt_q + 8'd1;
			ph_n      = PH_VALUE;
			if (cnt_n >= max_len)
				fin = 1'b1;
		end

		// terminal word goes after any value byte of the same body word
		if ((fin || body.body_last) && ph_n != PH_DONE) begin
			if (ph_n == PH_VALUE || ph_n == PH_ESCAPE) begin
				if (res.count == 2'd0)
					res.first = make_result(KIND_DONE, 8'd0, cnt_n);
				else
					res.second = make_result(KIND_DONE, 8'd0, cnt_n);
			end else begin
				if (res.count == 2'd0)
					res.first = make_result(KIND_NOT_FOUND, 8'd0, 8'd0);
				else
					res.second = make_result(KIND_NOT_FOUND, 8'd0, 8'd0);
			end
			res.count = res.count + 2'd1;
			ph_n      = PH_DONE;
		end

		// end of body: start over for the next one
		if (body.body_last) begin
			ph_n   = PH_SEARCH;
			seen_n = ESC_NONE;
			acc_n  = '0;
			cnt_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			seen_q  <= ESC_NONE;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= ph_n;
			seen_q  <= seen_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
		end
	end

	assign phase = phase_q;

endmodule

>>> hdl/ffve_fifo.sv
// Result queue: takes up to two words per cycle, hands out one per cycle.
// Depends on ffve_pkg.
`timescale 1ns / 1ps

module ffve_fifo
	import ffve_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  result_pair_t         din,
	input  logic                 pop,
	output result_word_t         dout,
	output logic [RES_LVL_W-1:0] level
);

	result_word_t         mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_q, rd_q;
	logic [RES_LVL_W-1:0] level_q;
	logic [1:0]           n_in;

	assign n_in = push ? din.count : 2'd0;

	always_ff @(posedge clk) begin
		if (n_in != 2'd0)
			mem_q[wr_q] <= din.first;
		if (n_in == 2'd2)
			mem_q[wr_q + RES_PTR_W'(1)] <= din.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_W'(n_in);
			rd_q    <= rd_q + RES_PTR_W'(pop);
			level_q <= level_q + RES_LVL_W'(n_in) - RES_LVL_W'(pop);
		end
	end

	assign dout  = mem_q[rd_q];
	assign level = level_q;

endmodule

>>> hdl/form_field_value_extractor.sv
// Top level of the form field value extractor: config registers, match cell row,
// sequencer and result queue. Depends on ffve_pkg, ffve_cell, ffve_ctrl, ffve_fifo.
//
// Usage:
//  - body channel: one body byte per word, body_last on the final byte of a body.
//  - result channel: one word per decoded value byte (kind 0), then one terminal
//    word: kind 1 with the value length, or kind 2 when the tag or '=' is missing.
//    Bytes after the terminal word are dropped up to the end of the body.
//  - cfg channel: cfg_index 0 tag text, 1 tag length, 2 max value length;
//    always ready, takes effect for the next body word. Write only while idle.
//  - A body word's result words are written into the result queue when it is taken.
//  - Throughput: one body word per cycle while body_ready is high. A body word yields at most two result
//    words; the four-word result queue takes both in the same cycle.
//  - body_ready is high while at least two queue slots are free, so a stalled
//    receiver holds the body side once three or four words are queued.
//  - Reset clears the window cells, the sequencer and the queue; the registers
//    return to tag length 1, empty tag text and max value length 32.
`timescale 1ns / 1ps

module form_field_value_extractor
	import ffve_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         body_valid,
	output logic         body_ready,
	input  body_word_t   body,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	logic [63:0]          tag_text_q;
	logic [TAG_LEN_W-1:0] tag_length_q;
	logic [7:0]           max_len_q;

	logic [TAG_LEN_W-1:0] len;
	logic                 accept, shift, clear, tag_match;
	phase_t               phase;
	result_pair_t         res;
	logic [RES_LVL_W-1:0] level;

	logic [7:0] chain [MAX_TAG_CHARS+1];
	logic [MAX_TAG_CHARS-1:0] hits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_text_q   <= TAG_TEXT_RST;
			tag_length_q <= TAG_LENGTH_RST;
			max_len_q    <= MAX_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TAG_TEXT:   tag_text_q   <= cfg_data;
				REG_TAG_LENGTH: tag_length_q <= cfg_data[TAG_LEN_W-1:0];
				REG_MAX_LENGTH: max_len_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign len = (tag_length_q > TAG_LEN_W'(MAX_TAG_CHARS)) ?
		TAG_LEN_W'(MAX_TAG_CHARS) : tag_length_q;

	assign body_ready = level <= RES_LVL_W'(RES_DEPTH - 2);
	assign accept     = body_valid && body_ready;
	assign clear      = accept && body.body_last;
	assign shift      = accept && phase == PH_SEARCH && body.body_byte != 8'd0
		&& len != '0;

	assign chain[0] = body.body_byte;

	for (genvar j = 0; j < MAX_TAG_CHARS; j++) begin : g_cell
		logic [TAG_LEN_W-1:0] idx;
		logic                 active;

		// cell j takes in the byte j positions back; it meets tag char len-1-j
		assign active = TAG_LEN_W'(j) < len;
		assign idx    = len - TAG_LEN_W'(j) - TAG_LEN_W'(1);

		ffve_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift),
			.clear    (clear),
			.din      (chain[j]),
			.tag_char (tag_text_q[{idx[2:0], 3'b000} +: 8]),
			.active   (active),
			.dout     (chain[j+1]),
			.hit      (hits[j])
		);
	end

	assign tag_match = &hits;

	ffve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.body      (body),
		.tag_match (tag_match),
		.len_zero  (len == '0),
		.max_len   (max_len_q),
		.phase     (phase),
		.res       (res)
	);

	ffve_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (res),
		.pop    (result_valid && result_ready),
		.dout   (result),
		.level  (level)
	);

	assign result_valid = level != '0;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		level <= RES_LVL_W'(RES_DEPTH))
		else $error("result queue overflow");

	a_body_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && body.body_last |=> phase == PH_SEARCH)
		else $error("sequencer did not restart after last body word");

	a_terminal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind != KIND_BYTE |-> result.decoded_byte == 8'd0)
		else $error("terminal word carries a data byte");

	a_two_words_one_result_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.count == 2'd2 |-> res.first.result_kind == KIND_BYTE
			&& res.second.result_kind == KIND_DONE)
		else $error("bad pair of result words");

endmodule
